### rtl/arbs_pkg.sv
// arbs_pkg: widths, types and constants of the adaptive radius bin smoother
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package arbs_pkg;

   // sample and result widths
   localparam int SAMPLE_BITS = 16;
   localparam int OUT_BITS    = 18;

   // one cell per window slot, up to four results per request
   localparam int NUM_CELLS = 6;
   localparam int MAX_RES   = 4;

   // minimum count for a spread of radius one, two and three
   localparam int SPREAD1_MIN = 2;
   localparam int SPREAD2_MIN = 8;
   localparam int SPREAD3_MIN = 16;

   // divide by three: multiply by ceil(2^(N+1)/3), keep the bits from N+1 up
   localparam int DIV3_SHIFT = SAMPLE_BITS + 1;
   localparam logic [SAMPLE_BITS:0] DIV3_MULT =
      (SAMPLE_BITS + 1)'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

   typedef logic [SAMPLE_BITS-1:0] samp_type;
   typedef logic [OUT_BITS-1:0]    acc_type;
   typedef logic [1:0]             pend_type;
   typedef logic [2:0]             rcnt_type;

   // pending count at which the oldest open bin is complete
   localparam pend_type PEND_FULL = 2'd3;

   // shares of one sample for distance 0..3, plus its row flag
   typedef struct packed {
      logic                 last;
      samp_type [3:0]       part;
   } share_type;

   // one result
   typedef struct packed {
      acc_type smoothed;
      logic    row_end;
   } res_type;

endpackage

`default_nettype wire

### rtl/arbs_if.sv
// arbs_req_if / arbs_rsp_if: valid-ready channels of the bin smoother
// depends on arbs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface arbs_req_if;
   logic                valid;
   logic                ready;
   arbs_pkg::samp_type  sample;
   logic                last_bin;

   modport source (output valid, output sample, output last_bin, input ready);
   modport sink   (input valid, input sample, input last_bin, output ready);
endinterface

interface arbs_rsp_if;
   logic                valid;
   logic                ready;
   arbs_pkg::acc_type   smoothed;
   logic                row_end;

   modport source (output valid, output smoothed, output row_end, input ready);
   modport sink   (input valid, input smoothed, input row_end, output ready);
endinterface

`default_nettype wire

### rtl/adaptive_radius_bin_smoother_top.sv
// adaptive_radius_bin_smoother_top: share stage, chain of six cells, result buffer
// depends on arbs_pkg, arbs_if, arbs_share, arbs_cell, arbs_obuf
//
//   channel    dir   handshake        payload
//   req_chan   in    valid / ready    sample, last_bin
//   rsp_chan   out   valid / ready    smoothed, row_end
//
// one request per cycle while the result buffer has room; a bin's result leaves
// three bins after the bin, via the share register and then the result buffer
// a last bin with p bins still open gives p+1 results at once; the buffer
// drains one per cycle when rsp_chan is ready, and the next request waits on it
// synchronous reset clears the cells, the open count and both valid flags
// a stalled result holds the share stage, and a held stage clears req_chan.ready
`timescale 1ns / 1ps
`default_nettype none

module adaptive_radius_bin_smoother_top (
   input  logic        clock,
   input  logic        reset,
   arbs_req_if.sink    req_chan,
   arbs_rsp_if.source  rsp_chan
);

   logic                                       s1_valid_ff;
   logic                                       s1_valid_in;
   logic                                       req_accept;
   logic                                       advance;
   logic                                       can_load;
   logic                                       pop;
   logic                                       out_valid;
   arbs_pkg::res_type                          out_res;
   arbs_pkg::share_type                        sh;
   arbs_pkg::pend_type                         pend_ff;
   arbs_pkg::pend_type                         pend_in;
   arbs_pkg::acc_type                          cell_acc [arbs_pkg::NUM_CELLS];
   arbs_pkg::acc_type                          cell_sum [arbs_pkg::NUM_CELLS];
   arbs_pkg::acc_type                          cand [arbs_pkg::MAX_RES];
   arbs_pkg::res_type [arbs_pkg::MAX_RES-1:0]  load_res;
   arbs_pkg::rcnt_type                         load_cnt;

   // input handshake and share stage occupancy
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign advance        = s1_valid_ff && can_load;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign s1_valid_in    = req_accept || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // shares of the incoming sample
   arbs_share u_share (
      .clock     (clock),
      .load      (req_accept),
      .sample    (req_chan.sample),
      .last_bin  (req_chan.last_bin),
      .share_out (sh)
   );

   // chain of cells: cell g holds the bin at window slot g+1, newest at the end
   for (genvar g = 0; g < arbs_pkg::NUM_CELLS; g++) begin : g_cell
      localparam int DIST = (g < 2) ? (2 - g) : (g - 2);
      arbs_pkg::acc_type carry;

      if (g == arbs_pkg::NUM_CELLS - 1) begin : g_tail
         assign carry = '0;
      end else begin : g_link
         assign carry = cell_acc[g+1];
      end

      arbs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .clear    (sh.last),
         .carry_in (carry),
         .share_in (arbs_pkg::acc_type'(sh.part[DIST])),
         .sum_out  (cell_sum[g]),
         .acc_out  (cell_acc[g])
      );
   end

   // completed values: oldest bin leaving the window, then the three newest
   assign cand[0] = cell_acc[0] + arbs_pkg::acc_type'(sh.part[3]);
   assign cand[1] = cell_sum[0];
   assign cand[2] = cell_sum[1];
   assign cand[3] = cell_sum[2];

   // pack the results of this request from the oldest open bin on
   always_comb begin : p_pack
      logic [2:0] pick;
      pick = '0;
      for (int i = 0; i < arbs_pkg::MAX_RES; i++) begin
         pick = sh.last ? (3'(i) + 3'd3 - {1'b0, pend_ff}) : 3'd0;
         load_res[i].smoothed = cand[pick[1:0]];
         load_res[i].row_end  = sh.last && (pend_ff == 2'(i));
      end
   end

   assign load_cnt = sh.last ? ({1'b0, pend_ff} + 3'd1) :
                     ((pend_ff == arbs_pkg::PEND_FULL) ? 3'd1 : 3'd0);

   // open bin count
   always_comb begin
      pend_in = pend_ff;
      if (advance) begin
         if (sh.last) begin
            pend_in = '0;
         end else if (pend_ff != arbs_pkg::PEND_FULL) begin
            pend_in = pend_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // result buffer
   assign pop = out_valid && rsp_chan.ready;

   arbs_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_cnt  (load_cnt),
      .load_res  (load_res),
      .pop       (pop),
      .out_valid (out_valid),
      .out_res   (out_res),
      .can_load  (can_load)
   );

   assign rsp_chan.valid    = out_valid;
   assign rsp_chan.smoothed = out_res.smoothed;
   assign rsp_chan.row_end  = out_res.row_end;

`ifndef SYNTHESIS
   // a row end leaves the chain and the open count empty
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && sh.last) |=> (pend_ff == '0 && cell_acc[0] == '0 &&
         cell_acc[1] == '0 && cell_acc[2] == '0 && cell_acc[3] == '0 &&
         cell_acc[4] == '0 && cell_acc[5] == '0))
      else $error("cells not cleared after row end");

   // a full window produces a result on the next cycle
   a_emit_full: assert property (@(posedge clock) disable iff (reset)
      (advance && !sh.last && pend_ff == arbs_pkg::PEND_FULL) |=> rsp_chan.valid)
      else $error("complete bin not delivered");

   // a bin inside a row leaves at least one open bin
   a_pend_grows: assert property (@(posedge clock) disable iff (reset)
      (advance && !sh.last) |=> (pend_ff != '0))
      else $error("open bin count lost");

   // a waiting share stage keeps its request
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(sh)))
      else $error("share stage lost a waiting request");
`endif

endmodule

`default_nettype wire

### rtl/arbs_share.sv
// arbs_share: registered shares v, v/2, v/3, v/4 of one sample by spread radius
// depends on arbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module arbs_share (
   input  logic                 clock,
   input  logic                 load,
   input  arbs_pkg::samp_type   sample,
   input  logic                 last_bin,
   output arbs_pkg::share_type  share_out
);

   localparam int PROD_BITS = 2 * arbs_pkg::SAMPLE_BITS + 1;

   logic [PROD_BITS-1:0] prod;
   arbs_pkg::samp_type   third;
   arbs_pkg::share_type  share_ff;
   arbs_pkg::share_type  share_in;

   // floor(v/3) by reciprocal multiply
   assign prod  = PROD_BITS'(sample) * PROD_BITS'(arbs_pkg::DIV3_MULT);
   assign third = prod[PROD_BITS-1 -: arbs_pkg::SAMPLE_BITS];

   // shares gated by the radius the count reaches
   always_comb begin
      share_in.last    = last_bin;
      share_in.part[0] = sample;
      share_in.part[1] = (sample >= arbs_pkg::samp_type'(arbs_pkg::SPREAD1_MIN)) ?
                         (sample >> 1) : '0;
      share_in.part[2] = (sample >= arbs_pkg::samp_type'(arbs_pkg::SPREAD2_MIN)) ?
                         third : '0;
      share_in.part[3] = (sample >= arbs_pkg::samp_type'(arbs_pkg::SPREAD3_MIN)) ?
                         (sample >> 2) : '0;
   end

   // share register
   always_ff @(posedge clock) begin
      if (load) begin
         share_ff <= share_in;
      end
   end

   assign share_out = share_ff;

endmodule

`default_nettype wire

### rtl/arbs_cell.sv
// arbs_cell: one accumulator of the smoothing chain, takes its neighbor's sum
// depends on arbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module arbs_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               clear,
   input  arbs_pkg::acc_type  carry_in,
   input  arbs_pkg::acc_type  share_in,
   output arbs_pkg::acc_type  sum_out,
   output arbs_pkg::acc_type  acc_out
);

   arbs_pkg::acc_type acc_ff;
   arbs_pkg::acc_type acc_in;

   // neighbor's partial sum plus this bin's share of the new sample
   assign sum_out = carry_in + share_in;
   assign acc_in  = clear ? '0 : sum_out;

   // accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (advance) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;

endmodule

`default_nettype wire

### rtl/arbs_obuf.sv
// arbs_obuf: four-slot result shift buffer, loaded with all results of a request
// depends on arbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module arbs_obuf (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         load,
   input  arbs_pkg::rcnt_type                           load_cnt,
   input  arbs_pkg::res_type [arbs_pkg::MAX_RES-1:0]    load_res,
   input  logic                                         pop,
   output logic                                         out_valid,
   output arbs_pkg::res_type                            out_res,
   output logic                                         can_load
);

   arbs_pkg::res_type [arbs_pkg::MAX_RES-1:0] slot_ff;
   arbs_pkg::res_type [arbs_pkg::MAX_RES-1:0] slot_in;
   arbs_pkg::rcnt_type                        cnt_ff;
   arbs_pkg::rcnt_type                        cnt_in;

   // room for a new batch once the last held result leaves
   assign can_load = (cnt_ff == '0) || ((cnt_ff == 3'd1) && pop);

   // load a batch or shift toward the head
   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         slot_in = load_res;
         cnt_in  = load_cnt;
      end else if (pop) begin
         for (int i = 0; i < arbs_pkg::MAX_RES - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
         cnt_in = cnt_ff - 3'd1;
      end
   end

   // count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // slots
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign out_valid = (cnt_ff != '0);
   assign out_res   = slot_ff[0];

endmodule

`default_nettype wire
